### hw/rtl/ths_pkg.sv
// Shared types and constants for the tar header size screener.
// Used by ths_front, ths_queue, ths_back and tar_header_size_screener; no dependencies.
package ths_pkg;

    localparam int BLOCK_SIZE  = 512;
    localparam int OFFSET_W    = $clog2(BLOCK_SIZE);
    localparam int SIZE_OFFSET = 124;
    localparam int SIZE_DIGITS = 12;
    localparam int TYPE_OFFSET = 156;

    localparam int SIZE_W  = 36;
    localparam int SKIP_W  = SIZE_W + 1;
    localparam int SUM_W   = 49;
    localparam int ENTRY_W = 21;
    localparam int LEN_W   = 48;
    localparam int MAXU_W  = 48;
    localparam int MAXE_W  = 20;
    localparam int PROD_W  = LEN_W + 6;

    localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};
    localparam logic [MAXU_W-1:0] MAXU_RESET = 48'd10737418240;
    localparam logic [MAXE_W-1:0] MAXE_RESET = 20'd10000;

    localparam logic [7:0] TYPE_REGULAR    = 8'h30;
    localparam logic [7:0] TYPE_REGULAR_OLD = 8'h00;
    localparam logic [7:0] TYPE_CONTIGUOUS = 8'h37;
    localparam logic [4:0] OCTAL_PREFIX    = 5'b00110;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BYTES   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ENTRIES = 1'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_FIELD_W = 3 + 2 + 1 + ENTRY_W + SUM_W + LEN_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [2:0] {
        LEVEL_NONE     = 3'd0,
        LEVEL_LOW      = 3'd1,
        LEVEL_MEDIUM   = 3'd2,
        LEVEL_HIGH     = 3'd3,
        LEVEL_CRITICAL = 3'd4
    } level_t;

    typedef enum logic [1:0] {
        FLAG_NONE  = 2'd0,
        FLAG_SIZE  = 2'd1,
        FLAG_ENTRY = 2'd2,
        FLAG_RATIO = 2'd3
    } flag_t;

    typedef struct packed {
        level_t               level;
        flag_t                flag;
        logic [ENTRY_W-1:0]   entries;
        logic [SUM_W-1:0]     content;
        logic [LEN_W-1:0]     length;
    } tally_t;

endpackage

### hw/rtl/ths_front.sv
// Front scanner: takes archive bytes, parses header blocks, skips content and applies limits.
// Emits one tally record per archive on the last byte. Depends on ths_pkg.
module ths_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ths_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ths_pkg::MAXU_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         in_byte,
    input  logic                               in_last,
    output logic                               rec_valid,
    input  logic                               rec_ready,
    output ths_pkg::tally_t                    rec
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    localparam logic [ths_pkg::OFFSET_W-1:0] OFFSET_LAST = ths_pkg::OFFSET_W'(ths_pkg::BLOCK_SIZE - 1);
    localparam logic [ths_pkg::OFFSET_W-1:0] OFF_SIZE_LO = ths_pkg::OFFSET_W'(ths_pkg::SIZE_OFFSET);
    localparam logic [ths_pkg::OFFSET_W-1:0] OFF_SIZE_HI =
        ths_pkg::OFFSET_W'(ths_pkg::SIZE_OFFSET + ths_pkg::SIZE_DIGITS);
    localparam logic [ths_pkg::OFFSET_W-1:0] OFF_TYPE = ths_pkg::OFFSET_W'(ths_pkg::TYPE_OFFSET);

    phase_t                          phase_reg, phase_next;
    logic [ths_pkg::OFFSET_W-1:0]    offset_reg, offset_next;
    logic                            allzero_reg, allzero_next;
    logic [ths_pkg::SIZE_W-1:0]      acc_reg, acc_next;
    logic                            stopped_reg, stopped_next;
    logic [7:0]                      type_reg, type_next;
    logic [1:0]                      run_reg, run_next;
    logic [ths_pkg::SKIP_W-1:0]      skip_reg, skip_next;
    logic [ths_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [ths_pkg::ENTRY_W-1:0]     ent_reg, ent_next;
    logic [ths_pkg::LEN_W-1:0]       cnt_reg, cnt_next;
    ths_pkg::level_t                 level_reg, level_next;
    ths_pkg::flag_t                  flag_reg, flag_next;
    logic [ths_pkg::MAXU_W-1:0]      maxu_reg;
    logic [ths_pkg::MAXE_W-1:0]      maxe_reg;

    logic                            accept;
    logic                            in_window;
    logic                            block_zero;
    logic                            is_regular;
    logic [1:0]                      run_inc;
    logic [ths_pkg::SUM_W-1:0]       sum_add;
    logic [ths_pkg::ENTRY_W-1:0]     ent_inc;
    logic [ths_pkg::ENTRY_W-1:0]     ent_after;
    logic                            size_over;
    logic                            entry_over;
    logic [ths_pkg::SKIP_W-1:0]      size_round;

    assign cfg_ready  = 1'b1;
    assign in_ready   = rec_ready;
    assign accept     = in_valid && rec_ready;
    assign rec_valid  = accept && in_last;

    assign in_window  = (offset_reg >= OFF_SIZE_LO) && (offset_reg < OFF_SIZE_HI);
    assign block_zero = allzero_reg && (in_byte == 8'h00);
    assign is_regular = (type_reg == ths_pkg::TYPE_REGULAR) ||
                        (type_reg == ths_pkg::TYPE_REGULAR_OLD) ||
                        (type_reg == ths_pkg::TYPE_CONTIGUOUS);
    assign run_inc    = (run_reg == 2'd3) ? run_reg : run_reg + 2'd1;
    assign sum_add    = sum_reg + {{(ths_pkg::SUM_W - ths_pkg::SIZE_W){1'b0}}, acc_reg};
    assign ent_inc    = ent_reg + 1'b1;
    assign ent_after  = is_regular ? ent_inc : ent_reg;
    assign size_over  = is_regular && (sum_add > {1'b0, maxu_reg});
    assign entry_over = ent_after > {{(ths_pkg::ENTRY_W - ths_pkg::MAXE_W){1'b0}}, maxe_reg};
    assign size_round = {1'b0, acc_reg} + ths_pkg::SKIP_W'(ths_pkg::BLOCK_SIZE - 1);

    always_comb begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        allzero_next = allzero_reg;
        acc_next     = acc_reg;
        stopped_next = stopped_reg;
        type_next    = type_reg;
        run_next     = run_reg;
        skip_next    = skip_reg;
        sum_next     = sum_reg;
        ent_next     = ent_reg;
        cnt_next     = cnt_reg;
        level_next   = level_reg;
        flag_next    = flag_reg;

        if (accept) begin
            if (cnt_reg != ths_pkg::LEN_MAX) begin
                cnt_next = cnt_reg + 1'b1;
            end
            unique case (phase_reg)
                PH_HEADER: begin
                    if (in_byte != 8'h00) begin
                        allzero_next = 1'b0;
                    end
                    if (in_window && !stopped_reg) begin
                        if (in_byte[7:3] == ths_pkg::OCTAL_PREFIX) begin
                            acc_next = {acc_reg[ths_pkg::SIZE_W-4:0], in_byte[2:0]};
                        end else begin
                            stopped_next = 1'b1;
                        end
                    end
                    if (offset_reg == OFF_TYPE) begin
                        type_next = in_byte;
                    end
                    if (offset_reg == OFFSET_LAST) begin
                        offset_next  = '0;
                        allzero_next = 1'b1;
                        acc_next     = '0;
                        stopped_next = 1'b0;
                        type_next    = '0;
                        if (block_zero) begin
                            run_next = run_inc;
                            if (run_inc >= 2'd2) begin
                                phase_next = PH_DONE;
                            end
                        end else begin
                            run_next = '0;
                            if (is_regular) begin
                                sum_next = sum_add;
                                ent_next = ent_inc;
                            end
                            priority if (size_over) begin
                                level_next = ths_pkg::LEVEL_CRITICAL;
                                flag_next  = ths_pkg::FLAG_SIZE;
                                phase_next = PH_DONE;
                            end else if (entry_over) begin
                                level_next = ths_pkg::LEVEL_HIGH;
                                flag_next  = ths_pkg::FLAG_ENTRY;
                                phase_next = PH_DONE;
                            end else begin
                                skip_next  = {size_round[ths_pkg::SKIP_W-1:ths_pkg::OFFSET_W],
                                              {ths_pkg::OFFSET_W{1'b0}}};
                                phase_next = (size_round[ths_pkg::SKIP_W-1:ths_pkg::OFFSET_W] != '0)
                                             ? PH_SKIP : PH_HEADER;
                            end
                        end
                    end else begin
                        offset_next = offset_reg + 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (skip_reg != '0) begin
                        skip_next = skip_reg - 1'b1;
                    end
                    if (skip_reg <= ths_pkg::SKIP_W'(1)) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    phase_next = PH_HEADER;
                end
            endcase
        end

        rec.level   = level_next;
        rec.flag    = flag_next;
        rec.entries = ent_next;
        rec.content = sum_next;
        rec.length  = cnt_next;

        if (accept && in_last) begin
            phase_next   = PH_HEADER;
            offset_next  = '0;
            allzero_next = 1'b1;
            acc_next     = '0;
            stopped_next = 1'b0;
            type_next    = '0;
            run_next     = '0;
            skip_next    = '0;
            sum_next     = '0;
            ent_next     = '0;
            cnt_next     = '0;
            level_next   = ths_pkg::LEVEL_NONE;
            flag_next    = ths_pkg::FLAG_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            offset_reg  <= '0;
            allzero_reg <= 1'b1;
            acc_reg     <= '0;
            stopped_reg <= 1'b0;
            type_reg    <= '0;
            run_reg     <= '0;
            skip_reg    <= '0;
            sum_reg     <= '0;
            ent_reg     <= '0;
            cnt_reg     <= '0;
            level_reg   <= ths_pkg::LEVEL_NONE;
            flag_reg    <= ths_pkg::FLAG_NONE;
            maxu_reg    <= ths_pkg::MAXU_RESET;
            maxe_reg    <= ths_pkg::MAXE_RESET;
        end else begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            allzero_reg <= allzero_next;
            acc_reg     <= acc_next;
            stopped_reg <= stopped_next;
            type_reg    <= type_next;
            run_reg     <= run_next;
            skip_reg    <= skip_next;
            sum_reg     <= sum_next;
            ent_reg     <= ent_next;
            cnt_reg     <= cnt_next;
            level_reg   <= level_next;
            flag_reg    <= flag_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ths_pkg::CFG_MAX_BYTES) begin
                    maxu_reg <= cfg_data;
                end
                if (cfg_index == ths_pkg::CFG_MAX_ENTRIES) begin
                    maxe_reg <= cfg_data[ths_pkg::MAXE_W-1:0];
                end
            end
        end
    end

endmodule

### hw/rtl/ths_queue.sv
// Short queue of tally records between the front scanner and the result stage.
// Depends on ths_pkg.
module ths_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    output logic               push_ready,
    input  ths_pkg::tally_t    push_data,
    output logic               pop_valid,
    input  logic               pop,
    output ths_pkg::tally_t    pop_data
);

    localparam int PTR_W = (ths_pkg::QUEUE_DEPTH > 1) ? $clog2(ths_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ths_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ths_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ths_pkg::QUEUE_DEPTH);

    ths_pkg::tally_t     slot_reg [ths_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/ths_back.sv
// Result stage: grades the compression ratio of each tally and drives the result stream.
// Two registered stages with stall; depends on ths_pkg.
module ths_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  ths_pkg::tally_t                     q_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ths_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    ths_pkg::tally_t                  rec_reg;
    logic [ths_pkg::PROD_W-1:0]       m50_reg;
    logic [ths_pkg::PROD_W-1:0]       m10_reg;
    logic                             s1_valid_reg;
    logic                             out_valid_reg;
    logic [ths_pkg::OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic                             out_load;
    logic                             s1_take;
    logic [ths_pkg::PROD_W-1:0]       len_ext;
    logic [ths_pkg::PROD_W-1:0]       sum_ext;
    ths_pkg::level_t                  level;
    ths_pkg::flag_t                   flag;

    assign out_load = !out_valid_reg || m_tready;
    assign s1_take  = !s1_valid_reg || out_load;
    assign q_pop    = q_valid && s1_take;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign len_ext  = {{(ths_pkg::PROD_W - ths_pkg::LEN_W){1'b0}}, q_data.length};
    assign sum_ext  = {{(ths_pkg::PROD_W - ths_pkg::SUM_W){1'b0}}, rec_reg.content};

    always_comb begin
        level = rec_reg.level;
        flag  = rec_reg.flag;
        if (rec_reg.level == ths_pkg::LEVEL_NONE) begin
            if (sum_ext > m50_reg) begin
                level = ths_pkg::LEVEL_MEDIUM;
                flag  = ths_pkg::FLAG_RATIO;
            end else if (sum_ext > m10_reg) begin
                level = ths_pkg::LEVEL_LOW;
                flag  = ths_pkg::FLAG_RATIO;
            end
        end
        out_data_next = {{ths_pkg::OUT_PAD_W{1'b0}}, rec_reg.length, rec_reg.content,
                         rec_reg.entries, (level != ths_pkg::LEVEL_NONE), flag, level};
    end

    always_ff @(posedge aclk) begin
        if (s1_take) begin
            rec_reg <= q_data;
            m50_reg <= (len_ext << 5) + (len_ext << 4) + (len_ext << 1);
            m10_reg <= (len_ext << 3) + (len_ext << 1);
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_take) begin
                s1_valid_reg <= q_valid;
            end
            if (out_load) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

endmodule

### hw/rtl/tar_header_size_screener.sv
// Top level of the tar header size screener: front scanner, record queue and result stage.
// Depends on ths_pkg, ths_front, ths_queue and ths_back.
//
// The block takes one archive byte per clock cycle on the s_ stream and raises s_tready
// except when its two-entry record queue is full, which happens only when the m_ side has
// stalled on earlier results. Header parsing, content skipping and the limit checks finish
// in the cycle that accepts each byte. The byte marked with s_tlast closes the archive; its
// result is written to the record queue, then registered with its ratio products, and the
// graded result is registered again before it drives the m_ stream. Configuration writes
// are taken at once and should be made while no archive is in flight.
module tar_header_size_screener (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ths_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ths_pkg::MAXU_W-1:0]          cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: data_byte[7:0].
    input  logic [ths_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: alert_level[2:0], flag_code[4:3], alert_set[5], entry_total[26:6],
    // content_total[75:27], archive_length[123:76], zero fill[127:124].
    output logic [ths_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    logic               rec_valid;
    logic               rec_ready;
    ths_pkg::tally_t    rec;
    logic               q_valid;
    logic               q_pop;
    ths_pkg::tally_t    q_data;

    ths_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata[7:0]),
        .in_last   (s_tlast),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    ths_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (rec_valid),
        .push_ready (rec_ready),
        .push_data  (rec),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    ths_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
